[hdl/balu_pkg.sv]
// balu_pkg: operation codes, item and result types for the byte alu
// used by balu_core, the top level and the testbench; depends on nothing
`timescale 1ns / 1ps

package balu_pkg;

  localparam int unsigned SIGN_BIT = 7;
  localparam int unsigned BIT6     = 6;
  localparam logic [7:0]  ONE      = 8'd1;

  typedef enum logic [4:0] {
    OP_ADC = 5'd0,
    OP_SBC = 5'd1,
    OP_INC = 5'd2,
    OP_DEC = 5'd3,
    OP_INX = 5'd4,
    OP_INY = 5'd5,
    OP_DEX = 5'd6,
    OP_DEY = 5'd7,
    OP_AND = 5'd8,
    OP_EOR = 5'd9,
    OP_ORA = 5'd10,
    OP_BIT = 5'd11,
    OP_ASL = 5'd12,
    OP_LSR = 5'd13,
    OP_ROL = 5'd14,
    OP_ROR = 5'd15,
    OP_CMP = 5'd16,
    OP_CPX = 5'd17,
    OP_CPY = 5'd18
  } op_t;

  typedef struct packed {
    logic [4:0] operation;
    logic [7:0] operand;
    logic [7:0] accumulator;
    logic [7:0] index_x;
    logic [7:0] index_y;
    logic       carry;
    logic       overflow;
    logic       shift_accumulator;
  } alu_item_t;

  typedef struct packed {
    logic [7:0] accumulator;
    logic [7:0] index_x;
    logic [7:0] index_y;
    logic [7:0] write_value;
    logic       write_enable;
    logic       carry;
    logic       zero;
    logic       negative;
    logic       overflow;
  } alu_result_t;

endpackage

[hdl/balu_core.sv]
// balu_core: combinational datapath for one alu item, binary mode only
// depends on balu_pkg for the operation codes and item/result structs
`timescale 1ns / 1ps

module balu_core (
  input  balu_pkg::alu_item_t   item,
  output balu_pkg::alu_result_t result
);

  always_comb begin
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] m;
    logic [7:0] res;
    logic [7:0] src;
    logic [7:0] wv;
    logic [8:0] sum;
    logic       c;
    logic       v;
    logic       we;
    logic       n_from_res;

    a          = item.accumulator;
    x          = item.index_x;
    y          = item.index_y;
    m          = item.operand;
    c          = item.carry;
    v          = item.overflow;
    res        = item.accumulator;
    wv         = 8'd0;
    we         = 1'b0;
    n_from_res = 1'b1;
    sum        = 9'd0;
    src        = item.shift_accumulator ? item.accumulator : item.operand;

    case (item.operation)
      balu_pkg::OP_ADC: begin
        sum = {1'b0, a} + {1'b0, m} + {8'd0, c};
        res = sum[7:0];
        c   = sum[8];
        v   = ~(a[balu_pkg::SIGN_BIT] ^ m[balu_pkg::SIGN_BIT])
              & (a[balu_pkg::SIGN_BIT] ^ res[balu_pkg::SIGN_BIT]);
        a   = res;
      end
      balu_pkg::OP_SBC: begin
        // subtract as add of the complement, carry means no borrow
        sum = {1'b0, a} + {1'b0, ~m} + {8'd0, c};
        res = sum[7:0];
        c   = sum[8];
        v   = (a[balu_pkg::SIGN_BIT] ^ m[balu_pkg::SIGN_BIT])
              & (a[balu_pkg::SIGN_BIT] ^ res[balu_pkg::SIGN_BIT]);
        a   = res;
      end
      balu_pkg::OP_INC: begin
        res = m + balu_pkg::ONE;
        wv  = res;
        we  = 1'b1;
      end
      balu_pkg::OP_DEC: begin
        res = m - balu_pkg::ONE;
        wv  = res;
        we  = 1'b1;
      end
      balu_pkg::OP_INX: begin
        x   = x + balu_pkg::ONE;
        res = x;
      end
      balu_pkg::OP_INY: begin
        y   = y + balu_pkg::ONE;
        res = y;
      end
      balu_pkg::OP_DEX: begin
        x   = x - balu_pkg::ONE;
        res = x;
      end
      balu_pkg::OP_DEY: begin
        y   = y - balu_pkg::ONE;
        res = y;
      end
      balu_pkg::OP_AND: begin
        a   = a & m;
        res = a;
      end
      balu_pkg::OP_EOR: begin
        a   = a ^ m;
        res = a;
      end
      balu_pkg::OP_ORA: begin
        a   = a | m;
        res = a;
      end
      balu_pkg::OP_BIT: begin
        res        = a & m;
        v          = m[balu_pkg::BIT6];
        n_from_res = 1'b0;
      end
      balu_pkg::OP_ASL, balu_pkg::OP_LSR, balu_pkg::OP_ROL, balu_pkg::OP_ROR: begin
        case (item.operation)
          balu_pkg::OP_ASL: begin
            res = {src[6:0], 1'b0};
            c   = src[7];
          end
          balu_pkg::OP_LSR: begin
            res = {1'b0, src[7:1]};
            c   = src[0];
          end
          balu_pkg::OP_ROL: begin
            res = {src[6:0], c};
            c   = src[7];
          end
          default: begin
            res = {c, src[7:1]};
            c   = src[0];
          end
        endcase
        if (item.shift_accumulator) begin
          a = res;
        end else begin
          wv = res;
          we = 1'b1;
        end
      end
      balu_pkg::OP_CMP, balu_pkg::OP_CPX, balu_pkg::OP_CPY: begin
        case (item.operation)
          balu_pkg::OP_CMP: src = a;
          balu_pkg::OP_CPX: src = x;
          default:          src = y;
        endcase
        sum = {1'b0, src} - {1'b0, m};
        res = sum[7:0];
        c   = ~sum[8];
      end
      default: begin
        // unused codes act as no operation, flags follow a
        res = a;
      end
    endcase

    result.accumulator  = a;
    result.index_x      = x;
    result.index_y      = y;
    result.write_value  = wv;
    result.write_enable = we;
    result.carry        = c;
    result.zero         = (res == 8'd0);
    result.negative     = n_from_res ? res[balu_pkg::SIGN_BIT] : m[balu_pkg::SIGN_BIT];
    result.overflow     = v;
  end

endmodule

[hdl/byte_alu_with_status_flags.sv]
// byte_alu_with_status_flags: 6502-style byte alu, binary mode, with flag outputs
// depends on balu_pkg and balu_core
`timescale 1ns / 1ps

// Usage
// Input channel: in_valid / in_stall carry one item: the operation code,
// the operand byte, the current A, X, Y, carry and overflow, and the
// shift target select. An item is taken at a clock edge where in_valid
// is high and in_stall is low.
// Output channel: out_valid / out_stall carry one result per item: new
// A, X, Y, the write-back byte with its enable, and the C, Z, N, V flags.
// The item is captured in the input register, the datapath in balu_core
// works between that register and the result register, and the result
// is shown from the result register. Throughput is one item per cycle
// while out_stall is low, set by the single pass through balu_core.
// When the receiver holds out_stall, the result register keeps its value
// and the input register still fills if it is empty; in_stall rises once
// it holds an item, so at most one more item is taken.
// Reset (rst, synchronous, active high) empties both registers; no result
// is shown until a new item has been taken.

module byte_alu_with_status_flags (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [4:0] operation,
  input  logic [7:0] operand,
  input  logic [7:0] accumulator_in,
  input  logic [7:0] index_x_in,
  input  logic [7:0] index_y_in,
  input  logic       carry_in,
  input  logic       overflow_in,
  input  logic       shift_accumulator,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] accumulator_out,
  output logic [7:0] index_x_out,
  output logic [7:0] index_y_out,
  output logic [7:0] write_value,
  output logic       write_enable,
  output logic       carry_out,
  output logic       zero_out,
  output logic       negative_out,
  output logic       overflow_out
);

  balu_pkg::alu_item_t   item_reg;
  logic                  item_valid;
  balu_pkg::alu_result_t core_result;
  balu_pkg::alu_result_t result_reg;
  logic                  result_valid;
  logic                  result_load;
  logic                  item_load;

  // result register frees when empty or when taken this cycle
  assign result_load = item_valid && (!result_valid || !out_stall);
  assign in_stall    = item_valid && result_valid && out_stall;
  assign item_load   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= item_load || (item_valid && !result_load);
    end
  end

  always_ff @(posedge clk) begin
    if (item_load) begin
      item_reg.operation         <= operation;
      item_reg.operand           <= operand;
      item_reg.accumulator       <= accumulator_in;
      item_reg.index_x           <= index_x_in;
      item_reg.index_y           <= index_y_in;
      item_reg.carry             <= carry_in;
      item_reg.overflow          <= overflow_in;
      item_reg.shift_accumulator <= shift_accumulator;
    end
  end

  balu_core u_core (
    .item   (item_reg),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (!out_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result_reg <= core_result;
    end
  end

  assign out_valid       = result_valid;
  assign accumulator_out = result_reg.accumulator;
  assign index_x_out     = result_reg.index_x;
  assign index_y_out     = result_reg.index_y;
  assign write_value     = result_reg.write_value;
  assign write_enable    = result_reg.write_enable;
  assign carry_out       = result_reg.carry;
  assign zero_out        = result_reg.zero;
  assign negative_out    = result_reg.negative;
  assign overflow_out    = result_reg.overflow;

endmodule

[hdl/balu_checker.sv]
// balu_checker: port-level assertions for byte_alu_with_status_flags
// bound to the top level below; depends on no package
`timescale 1ns / 1ps

module balu_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] accumulator_out,
  input logic [7:0] write_value,
  input logic       write_enable
);

  // a held result stays shown
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(accumulator_out) && $stable(write_value))
    else $error("result changed while stalled");

  // input backs up only when the output is stalled with a result waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // write-back byte is zero unless it is to be stored
  a_wv_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_enable |-> write_value == 8'd0)
    else $error("write value nonzero without write enable");

endmodule

bind byte_alu_with_status_flags balu_checker u_balu_checker (.*);

[tb/byte_alu_with_status_flags_tb.sv]
// byte_alu_with_status_flags_tb: self-checking bench for the byte alu with status flags
// predicts every result in the bench and checks it field by field; depends on balu_pkg
`timescale 1ns / 1ps

module byte_alu_with_status_flags_tb;

  localparam logic [4:0] OP_UNDEF_LOW  = 5'd19;
  localparam logic [4:0] OP_UNDEF_HIGH = 5'd31;
  localparam int         HOLD_CYCLES   = 60;
  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         PRINT_CAP     = 100;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [4:0] operation = '0;
  logic [7:0] operand = '0;
  logic [7:0] accumulator_in = '0;
  logic [7:0] index_x_in = '0;
  logic [7:0] index_y_in = '0;
  logic       carry_in = 1'b0;
  logic       overflow_in = 1'b0;
  logic       shift_accumulator = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] accumulator_out;
  logic [7:0] index_x_out;
  logic [7:0] index_y_out;
  logic [7:0] write_value;
  logic       write_enable;
  logic       carry_out;
  logic       zero_out;
  logic       negative_out;
  logic       overflow_out;

  balu_pkg::alu_result_t awaited_results[$];
  int          mismatch_count = 0;
  int          result_index = 0;
  int          cycle_count = 0;
  int          sender_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_requests = 0;
  int          holds_taken = 0;
  int          hold_left = 0;

  byte_alu_with_status_flags i_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .operation         (operation),
    .operand           (operand),
    .accumulator_in    (accumulator_in),
    .index_x_in        (index_x_in),
    .index_y_in        (index_y_in),
    .carry_in          (carry_in),
    .overflow_in       (overflow_in),
    .shift_accumulator (shift_accumulator),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .accumulator_out   (accumulator_out),
    .index_x_out       (index_x_out),
    .index_y_out       (index_y_out),
    .write_value       (write_value),
    .write_enable      (write_enable),
    .carry_out         (carry_out),
    .zero_out          (zero_out),
    .negative_out      (negative_out),
    .overflow_out      (overflow_out)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL byte_alu_with_status_flags");
      $finish;
    end
  end

  function automatic balu_pkg::alu_result_t compute_alu_result(balu_pkg::alu_item_t it);
    balu_pkg::alu_result_t r;
    logic [7:0]  a, x, y, m, res, src, wv;
    logic [8:0]  sum;
    logic        c, v, we, neg_from_operand, shifted;
    a = it.accumulator;
    x = it.index_x;
    y = it.index_y;
    m = it.operand;
    c = it.carry;
    v = it.overflow;
    res = a;
    wv = '0;
    we = 1'b0;
    neg_from_operand = 1'b0;
    shifted = 1'b0;
    src = it.shift_accumulator ? a : m;
    case (it.operation)
      balu_pkg::OP_ADC: begin
        sum = {1'b0, a} + {1'b0, m} + {8'd0, c};
        res = sum[7:0];
        c = sum[8];
        v = ~(a[balu_pkg::SIGN_BIT] ^ m[balu_pkg::SIGN_BIT])
            & (a[balu_pkg::SIGN_BIT] ^ res[balu_pkg::SIGN_BIT]);
        a = res;
      end
      balu_pkg::OP_SBC: begin
        // subtract as add of the inverted operand, carry means no borrow
        sum = {1'b0, a} + {1'b0, ~m} + {8'd0, c};
        res = sum[7:0];
        c = sum[8];
        v = (a[balu_pkg::SIGN_BIT] ^ m[balu_pkg::SIGN_BIT])
            & (a[balu_pkg::SIGN_BIT] ^ res[balu_pkg::SIGN_BIT]);
        a = res;
      end
      balu_pkg::OP_INC: begin res = m + balu_pkg::ONE; wv = res; we = 1'b1; end
      balu_pkg::OP_DEC: begin res = m - balu_pkg::ONE; wv = res; we = 1'b1; end
      balu_pkg::OP_INX: begin x = x + balu_pkg::ONE; res = x; end
      balu_pkg::OP_INY: begin y = y + balu_pkg::ONE; res = y; end
      balu_pkg::OP_DEX: begin x = x - balu_pkg::ONE; res = x; end
      balu_pkg::OP_DEY: begin y = y - balu_pkg::ONE; res = y; end
      balu_pkg::OP_AND: begin a = a & m; res = a; end
      balu_pkg::OP_EOR: begin a = a ^ m; res = a; end
      balu_pkg::OP_ORA: begin a = a | m; res = a; end
      balu_pkg::OP_BIT: begin
        res = a & m;
        v = m[balu_pkg::BIT6];
        neg_from_operand = 1'b1;
      end
      balu_pkg::OP_ASL: begin
        res = {src[6:0], 1'b0};
        c = src[balu_pkg::SIGN_BIT];
        shifted = 1'b1;
      end
      balu_pkg::OP_LSR: begin
        res = {1'b0, src[7:1]};
        c = src[0];
        shifted = 1'b1;
      end
      balu_pkg::OP_ROL: begin
        res = {src[6:0], c};
        c = src[balu_pkg::SIGN_BIT];
        shifted = 1'b1;
      end
      balu_pkg::OP_ROR: begin
        res = {c, src[7:1]};
        c = src[0];
        shifted = 1'b1;
      end
      balu_pkg::OP_CMP: begin res = a - m; c = (a >= m); end
      balu_pkg::OP_CPX: begin res = x - m; c = (x >= m); end
      balu_pkg::OP_CPY: begin res = y - m; c = (y >= m); end
      default: res = a;
    endcase
    if (shifted) begin
      if (it.shift_accumulator) begin
        a = res;
      end else begin
        wv = res;
        we = 1'b1;
      end
    end
    r.accumulator = a;
    r.index_x = x;
    r.index_y = y;
    r.write_value = wv;
    r.write_enable = we;
    r.carry = c;
    r.zero = (res == 8'd0);
    r.negative = neg_from_operand ? m[balu_pkg::SIGN_BIT] : res[balu_pkg::SIGN_BIT];
    r.overflow = v;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("mismatch at result %0d: %s got %0h expected %0h",
               result_index, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(string what, logic [7:0] got, logic [7:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // results are sampled at the falling edge, where the handshake is settled
  always @(negedge clk) begin
    balu_pkg::alu_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result", accumulator_out, 8'd0);
      end else begin
        want = awaited_results.pop_front();
        check_field("accumulator_out", accumulator_out, want.accumulator);
        check_field("index_x_out", index_x_out, want.index_x);
        check_field("index_y_out", index_y_out, want.index_y);
        check_field("write_value", write_value, want.write_value);
        check_field("write_enable", 8'(write_enable), 8'(want.write_enable));
        check_field("carry_out", 8'(carry_out), 8'(want.carry));
        check_field("zero_out", 8'(zero_out), 8'(want.zero));
        check_field("negative_out", 8'(negative_out), 8'(want.negative));
        check_field("overflow_out", 8'(overflow_out), 8'(want.overflow));
      end
      result_index++;
    end
  end

  // receiver: random stall, or a long hold counted here when one is requested
  always @(posedge clk) begin
    if (hold_requests != holds_taken) begin
      holds_taken <= hold_requests;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // called just after a rising edge; returns just after the edge that took the item
  task automatic send_item(balu_pkg::alu_item_t it);
    logic stalled;
    operation <= it.operation;
    operand <= it.operand;
    accumulator_in <= it.accumulator;
    index_x_in <= it.index_x;
    index_y_in <= it.index_y;
    carry_in <= it.carry;
    overflow_in <= it.overflow;
    shift_accumulator <= it.shift_accumulator;
    in_valid <= 1'b1;
    do begin
      @(negedge clk);
      stalled = in_stall;
      if (!stalled) awaited_results.push_back(compute_alu_result(it));
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic sender_gap();
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  function automatic balu_pkg::alu_item_t make_item(
    logic [4:0] op, logic [7:0] m, logic [7:0] a, logic [7:0] x, logic [7:0] y,
    logic c, logic v, logic sa);
    balu_pkg::alu_item_t it;
    it.operation = op;
    it.operand = m;
    it.accumulator = a;
    it.index_x = x;
    it.index_y = y;
    it.carry = c;
    it.overflow = v;
    it.shift_accumulator = sa;
    return it;
  endfunction

  // bias toward the byte boundaries where carry, overflow and zero flip
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      3: return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic balu_pkg::alu_item_t random_item();
    logic [4:0] op;
    if ($urandom_range(19) == 0) op = 5'($urandom_range(OP_UNDEF_HIGH, OP_UNDEF_LOW));
    else op = 5'($urandom_range(balu_pkg::OP_CPY, balu_pkg::OP_ADC));
    return make_item(op, pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                     1'($urandom), 1'($urandom), 1'($urandom));
  endfunction

  task automatic run_random(int count, int idle_pct, int stall_level);
    sender_idle_pct = idle_pct;
    stall_pct = stall_level;
    repeat (count) begin
      sender_gap();
      send_item(random_item());
    end
    wait_drained();
  endtask

  task automatic test_directed();
    sender_idle_pct = 0;
    stall_pct = 0;
    send_item(make_item(balu_pkg::OP_ADC, 8'h01, 8'h7F, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    send_item(make_item(balu_pkg::OP_ADC, 8'h01, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0));
    send_item(make_item(balu_pkg::OP_ADC, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b1));
    send_item(make_item(balu_pkg::OP_SBC, 8'h01, 8'h80, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0));
    send_item(make_item(balu_pkg::OP_SBC, 8'h01, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    send_item(make_item(balu_pkg::OP_SBC, 8'h42, 8'h42, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0));
    send_item(make_item(balu_pkg::OP_INC, 8'hFF, 8'h12, 8'h34, 8'h56, 1'b1, 1'b1, 1'b1));
    send_item(make_item(balu_pkg::OP_DEC, 8'h00, 8'h12, 8'h34, 8'h56, 1'b0, 1'b0, 1'b0));
    send_item(make_item(balu_pkg::OP_INX, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0));
    send_item(make_item(balu_pkg::OP_INY, 8'h00, 8'h00, 8'h00, 8'h7F, 1'b0, 1'b0, 1'b0));
    send_item(make_item(balu_pkg::OP_DEX, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    send_item(make_item(balu_pkg::OP_DEY, 8'hFF, 8'hFF, 8'hFF, 8'h01, 1'b1, 1'b1, 1'b0));
    send_item(make_item(balu_pkg::OP_AND, 8'h0F, 8'hF0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    send_item(make_item(balu_pkg::OP_EOR, 8'hFF, 8'h7F, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    send_item(make_item(balu_pkg::OP_ORA, 8'h80, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    // bit test: flags from the operand, zero from the masked accumulator
    send_item(make_item(balu_pkg::OP_BIT, 8'hC0, 8'h3F, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0));
    send_item(make_item(balu_pkg::OP_BIT, 8'h01, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0));
    send_item(make_item(balu_pkg::OP_ASL, 8'h00, 8'h81, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1));
    send_item(make_item(balu_pkg::OP_ASL, 8'h80, 8'h55, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    send_item(make_item(balu_pkg::OP_LSR, 8'h01, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0));
    send_item(make_item(balu_pkg::OP_ROL, 8'h00, 8'h80, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1));
    send_item(make_item(balu_pkg::OP_ROR, 8'h01, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0));
    send_item(make_item(balu_pkg::OP_CMP, 8'h40, 8'h40, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    send_item(make_item(balu_pkg::OP_CPX, 8'h01, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0));
    send_item(make_item(balu_pkg::OP_CPY, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b1, 1'b0));
    // undefined codes pass everything through
    send_item(make_item(OP_UNDEF_LOW, 8'hAA, 8'h00, 8'h11, 8'h22, 1'b1, 1'b1, 1'b1));
    send_item(make_item(OP_UNDEF_HIGH, 8'h55, 8'h80, 8'h33, 8'h44, 1'b0, 1'b0, 1'b0));
    wait_drained();
  endtask

  task automatic test_no_idling();
    run_random(300, 0, 0);
  endtask

  task automatic test_sender_idle();
    run_random(200, 86, 0);
  endtask

  task automatic test_receiver_stall();
    run_random(200, 0, 86);
  endtask

  task automatic test_both_idle();
    run_random(200, 6, 6);
  endtask

  // the receiver holds off while items keep coming, so the block fills and stalls its input
  task automatic test_input_backpressure();
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_requests++;
    repeat (40) send_item(random_item());
    wait_drained();
    run_random(150, 20, 20);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_no_idling();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_input_backpressure();
    wait_drained();
    repeat (8) @(posedge clk);
    if (awaited_results.size() != 0)
      report_mismatch("results never arrived", 8'(awaited_results.size()), 8'd0);
    if (mismatch_count == 0) begin
      $display("PASS byte_alu_with_status_flags");
    end else begin
      $display("FAIL byte_alu_with_status_flags");
    end
    $finish;
  end

endmodule

[byte_alu_with_status_flags.f]
hdl/balu_pkg.sv
hdl/balu_core.sv
hdl/byte_alu_with_status_flags.sv
hdl/balu_checker.sv
tb/byte_alu_with_status_flags_tb.sv
